// ===== design/ndt_pkg.sv =====
package ndt_pkg;

    // Table geometry.
    localparam int SLOTS    = 256;
    localparam int NAME_LEN = 50;

    localparam int ID_W    = 8;
    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int USED_W  = $clog2(SLOTS + 1);
    localparam int PLEN_W  = $clog2(NAME_LEN + 1);

    // Character store: one row of NAME_LEN bytes per slot, plus one extra row
    // that buffers the name being received.
    localparam int CHAR_DEPTH = (SLOTS + 1) * NAME_LEN;
    localparam int CA_W       = $clog2(CHAR_DEPTH);

    localparam logic [CA_W-1:0]   PEND_BASE   = CA_W'(SLOTS * NAME_LEN);
    localparam logic [CA_W-1:0]   NAME_LEN_CA = CA_W'(NAME_LEN);
    localparam logic [PLEN_W-1:0] NAME_LEN_PL = PLEN_W'(NAME_LEN);
    localparam logic [USED_W-1:0] SLOTS_U     = USED_W'(SLOTS);

    // Slot descriptor kept in the descriptor memory.
    typedef struct packed {
        logic [ID_W-1:0]   owner;
        logic [PLEN_W-1:0] len;
    } t_slot_meta;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SERVER_ID = 1'b0;

    // Request and reply codes.
    localparam logic ACT_REGISTER = 1'b0;
    localparam logic ACT_LOOKUP   = 1'b1;
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_LOOKUP  = 1'b1;

endpackage

// ===== design/name_directory_table.sv =====
// Name directory: maps names to node ids.
//
// Input channel (i_in_valid / o_in_stall): one item per name byte, carrying
// i_action, i_sender_id and i_name_byte. Nonzero bytes are collected; a zero
// byte ends the name and starts the request selected by i_action on that item.
// A register request stores the name with i_sender_id in the next free slot
// and answers with an acknowledge; with the table full or the name longer
// than NAME_LEN it is dropped with no reply. A lookup scans filled slots from
// slot 0 upward and answers with the id of the first exact match.
//
// Output channel (o_out_valid / i_out_stall): one reply item per completed
// request. The reply sits in an output register; while the receiver stalls it
// holds, and nonzero name bytes keep being accepted behind it.
//
// Timing: a nonzero byte never stalls the input. After the zero byte of a
// register request the input stalls while the name is copied out of the
// receive row into its slot, one byte a cycle. A lookup stalls while it reads
// each slot descriptor, checks its length and, where the length matches,
// compares the name byte by byte. A held reply lengthens the stall.
// Reset clears the fill count and the receive state; no memory is cleared.
module name_directory_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request channel.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_action,
    input  logic [ndt_pkg::ID_W-1:0]     i_sender_id,
    input  logic [ndt_pkg::BYTE_W-1:0]   i_name_byte,
    // Reply channel.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_reply_kind,
    output logic [ndt_pkg::ID_W-1:0]     o_reply_dest,
    output logic [ndt_pkg::ID_W-1:0]     o_reply_source,
    output logic                         o_found,
    output logic [ndt_pkg::ID_W-1:0]     o_found_id,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ndt_pkg::PADDR_W-1:0]  paddr,
    input  logic [ndt_pkg::PDATA_W-1:0]  pwdata,
    output logic [ndt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;  // collecting name bytes
    localparam logic [2:0] S_COPY  = 3'd1;  // copying the name into its slot
    localparam logic [2:0] S_META  = 3'd2;  // reading a slot descriptor
    localparam logic [2:0] S_MCHK  = 3'd3;  // checking the descriptor length
    localparam logic [2:0] S_CHAR  = 3'd4;  // comparing characters
    localparam logic [2:0] S_REPLY = 3'd5;  // waiting for the output register

    // Storage: descriptors and the character rows.
    ndt_pkg::t_slot_meta           meta_mem [ndt_pkg::SLOTS];
    logic [ndt_pkg::BYTE_W-1:0]    char_mem [ndt_pkg::CHAR_DEPTH];

    // Control registers.
    logic [2:0]                    r_state, n_state;
    logic [ndt_pkg::PLEN_W-1:0]    r_plen, n_plen;
    logic                          r_too_long, n_too_long;
    logic [ndt_pkg::USED_W-1:0]    r_used, n_used;
    logic [ndt_pkg::CA_W-1:0]      r_fill_base, n_fill_base;
    logic [ndt_pkg::USED_W-1:0]    r_slot, n_slot;
    logic [ndt_pkg::CA_W-1:0]      r_base, n_base;
    logic [ndt_pkg::PLEN_W-1:0]    r_k, n_k;
    logic                          r_wv, n_wv;
    logic [ndt_pkg::PLEN_W-1:0]    r_widx, n_widx;
    logic                          r_out_valid, n_out_valid;
    logic [ndt_pkg::ID_W-1:0]      r_server_id;

    // Request and result registers.
    logic                          r_req_kind, n_req_kind;
    logic [ndt_pkg::ID_W-1:0]      r_req_dest, n_req_dest;
    logic                          r_res_found, n_res_found;
    logic [ndt_pkg::ID_W-1:0]      r_res_id, n_res_id;
    logic                          r_out_kind;
    logic [ndt_pkg::ID_W-1:0]      r_out_dest;
    logic [ndt_pkg::ID_W-1:0]      r_out_source;
    logic                          r_out_found;
    logic [ndt_pkg::ID_W-1:0]      r_out_id;

    // Memory read data.
    ndt_pkg::t_slot_meta           r_meta_q;
    logic [ndt_pkg::BYTE_W-1:0]    r_rd_a;
    logic [ndt_pkg::BYTE_W-1:0]    r_rd_b;

    // Memory ports.
    logic                          meta_we;
    logic                          char_we;
    logic [ndt_pkg::CA_W-1:0]      char_wa;
    logic [ndt_pkg::BYTE_W-1:0]    char_wd;
    logic                          rd_en_a, rd_en_b;
    logic [ndt_pkg::CA_W-1:0]      rd_addr_a, rd_addr_b;

    logic                          in_acc;
    logic                          out_free;
    logic                          cfg_wr;
    logic                          last_slot;
    logic [ndt_pkg::PLEN_W-1:0]    k_next;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == ndt_pkg::REG_SERVER_ID);
    assign k_next   = r_k + 1'b1;

    // The scan ends when the slot just checked is the last filled one.
    assign last_slot = (r_slot + 1'b1) == r_used;

    always_comb begin
        n_state     = r_state;
        n_plen      = r_plen;
        n_too_long  = r_too_long;
        n_used      = r_used;
        n_fill_base = r_fill_base;
        n_slot      = r_slot;
        n_base      = r_base;
        n_k         = r_k;
        n_wv        = 1'b0;
        n_widx      = r_k;
        n_req_kind  = r_req_kind;
        n_req_dest  = r_req_dest;
        n_res_found = r_res_found;
        n_res_id    = r_res_id;
        n_out_valid = r_out_valid && i_out_stall;

        meta_we   = 1'b0;
        char_we   = 1'b0;
        char_wa   = ndt_pkg::PEND_BASE + ndt_pkg::CA_W'(r_plen);
        char_wd   = i_name_byte;
        rd_en_a   = 1'b0;
        rd_en_b   = 1'b0;
        rd_addr_a = r_base;
        rd_addr_b = ndt_pkg::PEND_BASE;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_name_byte != '0) begin
                        if (r_plen < ndt_pkg::NAME_LEN_PL) begin
                            char_we = 1'b1;
                            n_plen  = r_plen + 1'b1;
                        end else begin
                            n_too_long = 1'b1;
                        end
                    end else begin
                        n_req_dest  = i_sender_id;
                        n_req_kind  = i_action;
                        n_res_found = 1'b0;
                        n_res_id    = '0;
                        if (i_action == ndt_pkg::ACT_REGISTER) begin
                            if (r_too_long || r_used == ndt_pkg::SLOTS_U) begin
                                // Dropped silently.
                                n_plen     = '0;
                                n_too_long = 1'b0;
                            end else begin
                                meta_we = 1'b1;
                                n_k     = '0;
                                n_state = S_COPY;
                            end
                        end else begin
                            if (r_too_long || r_used == '0) begin
                                n_state = S_REPLY;
                            end else begin
                                n_slot  = '0;
                                n_base  = '0;
                                n_state = S_META;
                            end
                        end
                    end
                end
            end

            S_COPY: begin
                // Read the receive row one byte ahead of the write.
                rd_addr_b = ndt_pkg::PEND_BASE + ndt_pkg::CA_W'(r_k);
                if (r_k < r_plen) begin
                    rd_en_b = 1'b1;
                    n_wv    = 1'b1;
                    n_k     = k_next;
                end
                if (r_wv) begin
                    char_we = 1'b1;
                    char_wa = r_fill_base + ndt_pkg::CA_W'(r_widx);
                    char_wd = r_rd_b;
                end
                if (r_k == r_plen && !r_wv) begin
                    n_used      = r_used + 1'b1;
                    n_fill_base = r_fill_base + ndt_pkg::NAME_LEN_CA;
                    n_state     = S_REPLY;
                end
            end

            S_META: begin
                n_state = S_MCHK;
            end

            S_MCHK: begin
                if (r_meta_q.len == r_plen) begin
                    if (r_plen == '0) begin
                        n_res_found = 1'b1;
                        n_res_id    = r_meta_q.owner;
                        n_state     = S_REPLY;
                    end else begin
                        rd_en_a = 1'b1;
                        rd_en_b = 1'b1;
                        n_k     = '0;
                        n_state = S_CHAR;
                    end
                end else if (last_slot) begin
                    n_state = S_REPLY;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_base  = r_base + ndt_pkg::NAME_LEN_CA;
                    n_state = S_META;
                end
            end

            S_CHAR: begin
                rd_addr_a = r_base + ndt_pkg::CA_W'(k_next);
                rd_addr_b = ndt_pkg::PEND_BASE + ndt_pkg::CA_W'(k_next);
                if (r_rd_a != r_rd_b) begin
                    if (last_slot) begin
                        n_state = S_REPLY;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_base  = r_base + ndt_pkg::NAME_LEN_CA;
                        n_state = S_META;
                    end
                end else if (k_next == r_plen) begin
                    n_res_found = 1'b1;
                    n_res_id    = r_meta_q.owner;
                    n_state     = S_REPLY;
                end else begin
                    rd_en_a = 1'b1;
                    rd_en_b = 1'b1;
                    n_k     = k_next;
                end
            end

            S_REPLY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_plen      = '0;
                    n_too_long  = 1'b0;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_plen      <= '0;
            r_too_long  <= 1'b0;
            r_used      <= '0;
            r_fill_base <= '0;
            r_slot      <= '0;
            r_base      <= '0;
            r_k         <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_server_id <= '0;
        end else begin
            r_state     <= n_state;
            r_plen      <= n_plen;
            r_too_long  <= n_too_long;
            r_used      <= n_used;
            r_fill_base <= n_fill_base;
            r_slot      <= n_slot;
            r_base      <= n_base;
            r_k         <= n_k;
            r_wv        <= n_wv;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_server_id <= pwdata[ndt_pkg::ID_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_widx      <= n_widx;
        r_req_kind  <= n_req_kind;
        r_req_dest  <= n_req_dest;
        r_res_found <= n_res_found;
        r_res_id    <= n_res_id;
        if (r_state == S_REPLY && out_free) begin
            r_out_kind   <= r_req_kind;
            r_out_dest   <= r_req_dest;
            r_out_source <= r_server_id;
            r_out_found  <= r_res_found;
            r_out_id     <= r_res_id;
        end
    end

    // Descriptor memory: written at the next free slot, read at the scan slot.
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            meta_mem[r_used[ndt_pkg::SLOT_W-1:0]] <= '{owner: i_sender_id, len: r_plen};
        end
        r_meta_q <= meta_mem[r_slot[ndt_pkg::SLOT_W-1:0]];
    end

    // Character memory: one write port, two read ports.
    always_ff @(posedge i_clk) begin
        if (char_we) begin
            char_mem[char_wa] <= char_wd;
        end
        if (rd_en_a) begin
            r_rd_a <= char_mem[rd_addr_a];
        end
        if (rd_en_b) begin
            r_rd_b <= char_mem[rd_addr_b];
        end
    end

    assign o_in_stall     = r_state != S_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_reply_kind   = r_out_kind;
    assign o_reply_dest   = r_out_dest;
    assign o_reply_source = r_out_source;
    assign o_found        = r_out_found;
    assign o_found_id     = r_out_id;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ndt_pkg::REG_SERVER_ID)
                    ? ndt_pkg::PDATA_W'(r_server_id) : '0;

endmodule

// ===== design/ndt_checker.sv =====
module ndt_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_stall,
    input  logic [ndt_pkg::BYTE_W-1:0]   i_name_byte,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  logic                         o_reply_kind,
    input  logic [ndt_pkg::ID_W-1:0]     o_reply_dest,
    input  logic [ndt_pkg::ID_W-1:0]     o_reply_source,
    input  logic                         o_found,
    input  logic [ndt_pkg::ID_W-1:0]     o_found_id
);

    // A stalled reply holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_reply_kind)
            && $stable(o_reply_dest) && $stable(o_reply_source)
            && $stable(o_found) && $stable(o_found_id))
        else $error("reply changed while stalled");

    // An acknowledge never reports a match.
    a_ack_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reply_kind == ndt_pkg::KIND_ACK |-> !o_found && o_found_id == '0)
        else $error("acknowledge carries a match");

    // A miss reports id zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_found_id == '0)
        else $error("miss with nonzero id");

    // A nonzero name byte starts no work, so the next byte is taken at once.
    a_byte_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_name_byte != '0 |=> !o_in_stall)
        else $error("stalled after a name byte");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("reply valid after reset");

endmodule

bind name_directory_table ndt_checker u_ndt_checker (.*);
